// File: src/ece_pkg.sv
// Shared constants, types and helper functions for the easing curve evaluator.
// Holds the fixed-point formats, curve codes, pipeline stage structs and the
// elaboration-time builder for the spring decay ROM. No dependencies.
package ece_pkg;

    // Field formats
    localparam int FRAC_BITS         = 16;
    localparam int SPRING_TABLE_BITS = 10;
    localparam int FUNC_W            = 4;
    localparam int PROG_W            = 19;
    localparam int EASED_W           = 18;
    localparam int S_TDATA_W         = ((PROG_W + 7) / 8) * 8;
    localparam int S_TUSER_W         = FUNC_W;
    localparam int M_TDATA_W         = ((EASED_W + 7) / 8) * 8;

    // Internal widths
    localparam int T_W    = FRAC_BITS + 1;           // clamped progress, 0..ONE
    localparam int OP_W   = FRAC_BITS + 4;           // signed multiplier operand
    localparam int RES_W  = OP_W + 3;                // result before saturation
    localparam int E_W    = FRAC_BITS + 2;           // spring ROM entry
    localparam int ROM_N  = 1 << SPRING_TABLE_BITS;
    localparam int ADDR_W = SPRING_TABLE_BITS + 1;   // ROM has ROM_N + 1 entries
    localparam int POS_W  = T_W + SPRING_TABLE_BITS;

    // Fixed-point constants
    localparam longint ONE_Q     = longint'(1) <<< FRAC_BITS;
    localparam longint HALF_Q    = ONE_Q >>> 1;
    localparam longint C1_Q      = (longint'(170158) * ONE_Q + longint'(50000))
                                   / longint'(100000);
    localparam longint C2_Q      = (longint'(259490950) * ONE_Q + longint'(50000000))
                                   / longint'(100000000);
    localparam longint C3_Q      = C1_Q + ONE_Q;
    localparam longint CV_Q      = C2_Q + ONE_Q;
    localparam longint SAT_MAX_Q = (longint'(1) <<< (EASED_W - 1)) - 1;
    localparam longint SAT_MIN_Q = -(longint'(1) <<< (EASED_W - 1));

    localparam logic signed [OP_W-1:0] ONE_OP  = OP_W'(ONE_Q);
    localparam logic signed [OP_W-1:0] TWO_OP  = OP_W'(2 * ONE_Q);
    localparam logic signed [OP_W-1:0] FOUR_OP = OP_W'(4 * ONE_Q);
    localparam logic signed [OP_W-1:0] C1_OP   = OP_W'(C1_Q);
    localparam logic signed [OP_W-1:0] C2_OP   = OP_W'(C2_Q);
    localparam logic signed [OP_W-1:0] C3_OP   = OP_W'(C3_Q);
    localparam logic signed [OP_W-1:0] CV_OP   = OP_W'(CV_Q);
    localparam logic        [T_W-1:0]  ONE_T   = T_W'(ONE_Q);
    localparam logic        [T_W-1:0]  HALF_T  = T_W'(HALF_Q);

    localparam logic signed [RES_W-1:0] ONE_R     = RES_W'(ONE_Q);
    localparam logic signed [RES_W-1:0] TWO_R     = RES_W'(2 * ONE_Q);
    localparam logic signed [RES_W-1:0] SAT_MAX_R = RES_W'(SAT_MAX_Q);
    localparam logic signed [RES_W-1:0] SAT_MIN_R = RES_W'(SAT_MIN_Q);

    // Curve selector codes (anything else is linear)
    localparam logic [FUNC_W-1:0] FUNC_LINEAR      = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUAD_IN     = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUAD_OUT    = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUAD_INOUT  = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_CUBIC_IN    = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_CUBIC_OUT   = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_CUBIC_INOUT = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_BACK_IN     = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_BACK_OUT    = 4'd8;
    localparam logic [FUNC_W-1:0] FUNC_BACK_INOUT  = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_SPRING      = 4'd10;

    // How the last stage assembles the result
    typedef enum logic [3:0] {
        FIN_T          = 4'd0,
        FIN_M1         = 4'd1,
        FIN_M1X2       = 4'd2,
        FIN_M1_SUB_ONE = 4'd3,
        FIN_M2         = 4'd4,
        FIN_M2X4       = 4'd5,
        FIN_M2_ADD_ONE = 4'd6,
        FIN_BACK_IN    = 4'd7,
        FIN_BACK_OUT   = 4'd8,
        FIN_BACK_IO_LO = 4'd9,
        FIN_BACK_IO_HI = 4'd10,
        FIN_SPRING     = 4'd11
    } fin_t;

    // Stage 0: decoded request
    typedef struct packed {
        fin_t                    fin;
        logic [T_W-1:0]          t;
        logic signed [OP_W-1:0]  a1;
        logic signed [OP_W-1:0]  b1;
        logic signed [OP_W-1:0]  c;
        logic signed [OP_W-1:0]  ub;
        logic [ADDR_W-1:0]       addr0;
        logic [ADDR_W-1:0]       addr1;
        logic [FRAC_BITS-1:0]    fr;
    } op_t;

    // Stage 1: first product
    typedef struct packed {
        fin_t                    fin;
        logic [T_W-1:0]          t;
        logic signed [OP_W-1:0]  m1;
        logic signed [OP_W-1:0]  v;
        logic signed [OP_W-1:0]  c;
        logic [FRAC_BITS-1:0]    fr;
    } s1_t;

    // Stage 2: second product
    typedef struct packed {
        fin_t                    fin;
        logic [T_W-1:0]          t;
        logic signed [OP_W-1:0]  m1;
        logic signed [OP_W-1:0]  m2;
        logic signed [E_W-1:0]   e0;
    } s2_t;

    // Stage 3: back-curve constant products
    typedef struct packed {
        fin_t                    fin;
        logic [T_W-1:0]          t;
        logic signed [OP_W-1:0]  m1;
        logic signed [OP_W-1:0]  m2;
        logic signed [OP_W-1:0]  m3a;
        logic signed [OP_W-1:0]  m3b;
        logic signed [E_W-1:0]   e0;
    } s3_t;

    typedef logic signed [E_W-1:0] spring_rom_t [0:ROM_N];

    // Fixed-point product, floor towards minus infinity
    function automatic logic signed [OP_W-1:0] qmul(
        input logic signed [OP_W-1:0] a,
        input logic signed [OP_W-1:0] b
    );
        logic signed [2*OP_W-1:0] p;
        p = a * b;
        return p[FRAC_BITS +: OP_W];
    endfunction

    // Signed quotient truncated towards zero, by shift and subtract;
    // used at elaboration only
    function automatic longint div_trunc(
        input longint num,
        input longint den
    );
        longint unsigned a;
        longint unsigned d;
        longint unsigned q;
        longint unsigned rem;
        logic            neg;
        int              b;
        neg = (num < 0) != (den < 0);
        a   = unsigned'((num < 0) ? -num : num);
        d   = unsigned'((den < 0) ? -den : den);
        q   = 64'd0;
        rem = 64'd0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], a[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return neg ? -signed'(q) : signed'(q);
    endfunction

    // Spring decay table: entry i = Re(z^i), z = exp((-10 + j10*sqrt3) / ROM_N),
    // all in Q30 with floor products; evaluated at elaboration only
    function automatic spring_rom_t build_spring_rom();
        spring_rom_t     rom;
        longint unsigned n;
        longint unsigned r;
        longint unsigned bitv;
        longint          wr;
        longint          wi;
        longint          tr;
        longint          ti;
        longint          zr;
        longint          zi;
        longint          pr;
        longint          pim;
        longint          nr;
        longint          ni;
        longint          kk;
        int              k;
        int              i;
        // integer square root of 3 * 2^60
        n    = 64'd3 << 60;
        r    = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > n) begin
            bitv = bitv >> 2;
        end
        while (bitv != 64'd0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        wr = div_trunc(-(longint'(10) <<< 30), longint'(ROM_N));
        wi = div_trunc(longint'(64'd10 * r), longint'(ROM_N));
        // complex Taylor series for z
        tr = longint'(1) <<< 30;
        ti = 0;
        zr = longint'(1) <<< 30;
        zi = 0;
        for (k = 1; k <= 24; k++) begin
            kk = longint'(k);
            nr = ((tr * wr) >>> 30) - ((ti * wi) >>> 30);
            ni = ((tr * wi) >>> 30) + ((ti * wr) >>> 30);
            tr = div_trunc(nr, kk);
            ti = div_trunc(ni, kk);
            zr = zr + tr;
            zi = zi + ti;
        end
        // successive powers
        pr     = longint'(1) <<< 30;
        pim    = 0;
        rom[0] = E_W'(ONE_Q);
        for (i = 1; i <= ROM_N; i++) begin
            nr     = ((pr * zr) >>> 30) - ((pim * zi) >>> 30);
            ni     = ((pr * zi) >>> 30) + ((pim * zr) >>> 30);
            pr     = nr;
            pim    = ni;
            rom[i] = E_W'((pr + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
        end
        return rom;
    endfunction

endpackage

// File: src/ece_spring_rom.sv
// Spring decay ROM with two registered read ports (entry and its neighbour).
// Contents are built at elaboration by ece_pkg::build_spring_rom.
// Depends on ece_pkg.
module ece_spring_rom (
    input  logic                                aclk,
    input  logic                                rd_en,
    input  logic [ece_pkg::ADDR_W-1:0]          addr_a,
    input  logic [ece_pkg::ADDR_W-1:0]          addr_b,
    output logic signed [ece_pkg::E_W-1:0]      data_a,
    output logic signed [ece_pkg::E_W-1:0]      data_b
);

    localparam ece_pkg::spring_rom_t SPRING_ROM = ece_pkg::build_spring_rom();

    logic signed [ece_pkg::E_W-1:0] rd_a_reg;
    logic signed [ece_pkg::E_W-1:0] rd_b_reg;

    // registered reads, held while the stage is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= SPRING_ROM[addr_a];
            rd_b_reg <= SPRING_ROM[addr_b];
        end
    end

    assign data_a = rd_a_reg;
    assign data_b = rd_b_reg;

endmodule

// File: src/ece_decode.sv
// Front end: clamps progress to [0, ONE] and maps the curve selector onto
// multiplier operands, a finishing code and the spring ROM addresses.
// Depends on ece_pkg.
module ece_decode (
    input  logic [ece_pkg::FUNC_W-1:0]          func,
    input  logic signed [ece_pkg::PROG_W-1:0]   progress,
    output ece_pkg::op_t                        op
);

    logic                               neg;
    logic                               over;
    logic                               half;
    logic [ece_pkg::T_W-1:0]            t;
    logic signed [ece_pkg::OP_W-1:0]    t_op;
    logic signed [ece_pkg::OP_W-1:0]    um1;
    logic signed [ece_pkg::OP_W-1:0]    two_t;
    logic signed [ece_pkg::OP_W-1:0]    u2m;
    logic signed [ece_pkg::OP_W-1:0]    four_m2t;
    logic signed [ece_pkg::OP_W-1:0]    two_m_t;
    logic [ece_pkg::POS_W-1:0]          pos;
    logic [ece_pkg::ADDR_W-1:0]         idx;

    // clamp
    assign neg  = progress[ece_pkg::PROG_W-1];
    assign over = !neg && (progress[ece_pkg::PROG_W-2:0] > (ece_pkg::PROG_W-1)'(ece_pkg::ONE_Q));

    always_comb begin
        if (neg) begin
            t = '0;
        end else if (over) begin
            t = ece_pkg::ONE_T;
        end else begin
            t = progress[ece_pkg::T_W-1:0];
        end
    end

    // common operand forms
    assign half     = t < ece_pkg::HALF_T;
    assign t_op     = $signed(ece_pkg::OP_W'(t));
    assign um1      = t_op - ece_pkg::ONE_OP;
    assign two_t    = t_op <<< 1;
    assign u2m      = two_t - ece_pkg::TWO_OP;
    assign four_m2t = ece_pkg::FOUR_OP - two_t;
    assign two_m_t  = ece_pkg::TWO_OP - t_op;

    // spring table position: top bits index, low bits interpolate
    assign pos = ece_pkg::POS_W'(t) << ece_pkg::SPRING_TABLE_BITS;
    assign idx = pos[ece_pkg::FRAC_BITS +: ece_pkg::ADDR_W];

    always_comb begin
        op.t     = t;
        op.fin   = ece_pkg::FIN_T;
        op.a1    = t_op;
        op.b1    = t_op;
        op.c     = t_op;
        op.ub    = '0;
        op.addr0 = idx;
        op.addr1 = (idx == ece_pkg::ADDR_W'(ece_pkg::ROM_N)) ? idx : idx + ece_pkg::ADDR_W'(1);
        op.fr    = pos[ece_pkg::FRAC_BITS-1:0];
        unique case (func)
            ece_pkg::FUNC_QUAD_IN: begin
                op.fin = ece_pkg::FIN_M1;
            end
            ece_pkg::FUNC_QUAD_OUT: begin
                op.b1  = two_m_t;
                op.fin = ece_pkg::FIN_M1;
            end
            ece_pkg::FUNC_QUAD_INOUT: begin
                if (half) begin
                    op.fin = ece_pkg::FIN_M1X2;
                end else begin
                    op.a1  = four_m2t;
                    op.fin = ece_pkg::FIN_M1_SUB_ONE;
                end
            end
            ece_pkg::FUNC_CUBIC_IN: begin
                op.fin = ece_pkg::FIN_M2;
            end
            ece_pkg::FUNC_CUBIC_OUT: begin
                op.a1  = um1;
                op.b1  = um1;
                op.c   = um1;
                op.fin = ece_pkg::FIN_M2_ADD_ONE;
            end
            ece_pkg::FUNC_CUBIC_INOUT: begin
                if (half) begin
                    op.fin = ece_pkg::FIN_M2X4;
                end else begin
                    op.a1  = um1;
                    op.b1  = u2m;
                    op.c   = u2m;
                    op.fin = ece_pkg::FIN_M2_ADD_ONE;
                end
            end
            ece_pkg::FUNC_BACK_IN: begin
                op.fin = ece_pkg::FIN_BACK_IN;
            end
            ece_pkg::FUNC_BACK_OUT: begin
                op.a1  = um1;
                op.b1  = um1;
                op.c   = um1;
                op.fin = ece_pkg::FIN_BACK_OUT;
            end
            ece_pkg::FUNC_BACK_INOUT: begin
                if (half) begin
                    op.a1  = two_t;
                    op.b1  = two_t;
                    op.ub  = two_t;
                    op.fin = ece_pkg::FIN_BACK_IO_LO;
                end else begin
                    op.a1  = u2m;
                    op.b1  = u2m;
                    op.ub  = u2m;
                    op.fin = ece_pkg::FIN_BACK_IO_HI;
                end
            end
            ece_pkg::FUNC_SPRING: begin
                op.fin = ece_pkg::FIN_SPRING;
            end
            default: begin
                op.fin = ece_pkg::FIN_T;
            end
        endcase
    end

endmodule

// File: src/ece_finish.sv
// Last stage: assembles the eased value from the stage products and
// saturates it to the output width. Depends on ece_pkg.
module ece_finish (
    input  ece_pkg::s3_t                        st,
    output logic signed [ece_pkg::EASED_W-1:0]  eased
);

    logic signed [ece_pkg::RES_W-1:0] t_x;
    logic signed [ece_pkg::RES_W-1:0] m1_x;
    logic signed [ece_pkg::RES_W-1:0] m2_x;
    logic signed [ece_pkg::RES_W-1:0] m3a_x;
    logic signed [ece_pkg::RES_W-1:0] m3b_x;
    logic signed [ece_pkg::RES_W-1:0] e0_x;
    logic signed [ece_pkg::RES_W-1:0] res;

    assign t_x   = $signed(ece_pkg::RES_W'(st.t));
    assign m1_x  = ece_pkg::RES_W'(st.m1);
    assign m2_x  = ece_pkg::RES_W'(st.m2);
    assign m3a_x = ece_pkg::RES_W'(st.m3a);
    assign m3b_x = ece_pkg::RES_W'(st.m3b);
    assign e0_x  = ece_pkg::RES_W'(st.e0);

    // per-curve combination
    always_comb begin
        unique case (st.fin)
            ece_pkg::FIN_M1:         res = m1_x;
            ece_pkg::FIN_M1X2:       res = m1_x <<< 1;
            ece_pkg::FIN_M1_SUB_ONE: res = m1_x - ece_pkg::ONE_R;
            ece_pkg::FIN_M2:         res = m2_x;
            ece_pkg::FIN_M2X4:       res = m2_x <<< 2;
            ece_pkg::FIN_M2_ADD_ONE: res = m2_x + ece_pkg::ONE_R;
            ece_pkg::FIN_BACK_IN:    res = m3a_x - m3b_x;
            ece_pkg::FIN_BACK_OUT:   res = ece_pkg::ONE_R + m3a_x + m3b_x;
            ece_pkg::FIN_BACK_IO_LO: res = m2_x >>> 1;
            ece_pkg::FIN_BACK_IO_HI: res = (m2_x + ece_pkg::TWO_R) >>> 1;
            ece_pkg::FIN_SPRING:     res = ece_pkg::ONE_R - e0_x - m2_x;
            default:                 res = t_x;
        endcase
    end

    // saturate to the output range
    always_comb begin
        if (res > ece_pkg::SAT_MAX_R) begin
            eased = ece_pkg::EASED_W'(ece_pkg::SAT_MAX_Q);
        end else if (res < ece_pkg::SAT_MIN_R) begin
            eased = ece_pkg::EASED_W'(ece_pkg::SAT_MIN_Q);
        end else begin
            eased = res[ece_pkg::EASED_W-1:0];
        end
    end

endmodule

// File: src/easing_curve_evaluator.sv
// Easing curve evaluator, five register stages: decode, product 1 / ROM read,
// product 2, constant products, result. Throughput: one request per cycle
// while m_tready is high; each stage refills as soon as its content moves on.
// Reset (aresetn low, synchronous) clears the stage valid flags only; the
// spring ROM is constant and needs no clearing. Uses ece_pkg and submodules.
module easing_curve_evaluator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ece_pkg::S_TDATA_W-1:0]   s_tdata,   // [18:0] progress
    input  logic [ece_pkg::S_TUSER_W-1:0]   s_tuser,   // [3:0] func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ece_pkg::M_TDATA_W-1:0]   m_tdata    // [17:0] eased
);

    ece_pkg::op_t   s0_next;
    ece_pkg::op_t   s0_reg;
    ece_pkg::s1_t   s1_next;
    ece_pkg::s1_t   s1_reg;
    ece_pkg::s2_t   s2_next;
    ece_pkg::s2_t   s2_reg;
    ece_pkg::s3_t   s3_next;
    ece_pkg::s3_t   s3_reg;

    logic s0_v_reg;
    logic s1_v_reg;
    logic s2_v_reg;
    logic s3_v_reg;
    logic out_v_reg;

    logic adv0;
    logic adv1;
    logic adv2;
    logic adv3;
    logic adv_out;

    logic signed [ece_pkg::EASED_W-1:0] eased_next;
    logic        [ece_pkg::EASED_W-1:0] eased_reg;

    logic signed [ece_pkg::E_W-1:0]     e0;
    logic signed [ece_pkg::E_W-1:0]     e1;
    logic signed [ece_pkg::OP_W-1:0]    vprod;
    logic signed [ece_pkg::OP_W-1:0]    diff;
    logic signed [ece_pkg::OP_W-1:0]    xm;
    logic signed [ece_pkg::OP_W-1:0]    ym;
    logic                               spring;
    logic                               back_io;

    // a stage loads when empty or when its content moves on
    assign adv_out  = !out_v_reg || m_tready;
    assign adv3     = !s3_v_reg || adv_out;
    assign adv2     = !s2_v_reg || adv3;
    assign adv1     = !s1_v_reg || adv2;
    assign adv0     = !s0_v_reg || adv1;
    assign s_tready = adv0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg  <= 1'b0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (adv0)    s0_v_reg  <= s_tvalid;
            if (adv1)    s1_v_reg  <= s0_v_reg;
            if (adv2)    s2_v_reg  <= s1_v_reg;
            if (adv3)    s3_v_reg  <= s2_v_reg;
            if (adv_out) out_v_reg <= s3_v_reg;
        end
    end

    // stage 0: clamp and decode
    ece_decode u_decode (
        .func     (s_tuser[ece_pkg::FUNC_W-1:0]),
        .progress ($signed(s_tdata[ece_pkg::PROG_W-1:0])),
        .op       (s0_next)
    );

    // stage 1: first product, back in-out slope term, ROM fetch
    assign vprod = ece_pkg::qmul(ece_pkg::CV_OP, s0_reg.ub);

    always_comb begin
        s1_next.fin = s0_reg.fin;
        s1_next.t   = s0_reg.t;
        s1_next.m1  = ece_pkg::qmul(s0_reg.a1, s0_reg.b1);
        s1_next.v   = (s0_reg.fin == ece_pkg::FIN_BACK_IO_LO) ? vprod - ece_pkg::C2_OP
                                                               : vprod + ece_pkg::C2_OP;
        s1_next.c   = s0_reg.c;
        s1_next.fr  = s0_reg.fr;
    end

    ece_spring_rom u_spring_rom (
        .aclk   (aclk),
        .rd_en  (adv1),
        .addr_a (s0_reg.addr0),
        .addr_b (s0_reg.addr1),
        .data_a (e0),
        .data_b (e1)
    );

    // stage 2: second product, or spring interpolation step
    assign spring  = s1_reg.fin == ece_pkg::FIN_SPRING;
    assign back_io = (s1_reg.fin == ece_pkg::FIN_BACK_IO_LO) ||
                     (s1_reg.fin == ece_pkg::FIN_BACK_IO_HI);
    assign diff    = ece_pkg::OP_W'(e1) - ece_pkg::OP_W'(e0);
    assign xm      = spring ? diff : s1_reg.m1;

    always_comb begin
        if (spring) begin
            ym = $signed(ece_pkg::OP_W'(s1_reg.fr));
        end else if (back_io) begin
            ym = s1_reg.v;
        end else begin
            ym = s1_reg.c;
        end
    end

    always_comb begin
        s2_next.fin = s1_reg.fin;
        s2_next.t   = s1_reg.t;
        s2_next.m1  = s1_reg.m1;
        s2_next.m2  = ece_pkg::qmul(xm, ym);
        s2_next.e0  = e0;
    end

    // stage 3: back-curve constant products
    always_comb begin
        s3_next.fin = s2_reg.fin;
        s3_next.t   = s2_reg.t;
        s3_next.m1  = s2_reg.m1;
        s3_next.m2  = s2_reg.m2;
        s3_next.m3a = ece_pkg::qmul(ece_pkg::C3_OP, s2_reg.m2);
        s3_next.m3b = ece_pkg::qmul(ece_pkg::C1_OP, s2_reg.m1);
        s3_next.e0  = s2_reg.e0;
    end

    // result: combine and saturate
    ece_finish u_finish (
        .st    (s3_reg),
        .eased (eased_next)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv0)    s0_reg    <= s0_next;
        if (adv1)    s1_reg    <= s1_next;
        if (adv2)    s2_reg    <= s2_next;
        if (adv3)    s3_reg    <= s3_next;
        if (adv_out) eased_reg <= eased_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = ece_pkg::M_TDATA_W'(eased_reg);

endmodule

// File: src/ece_checker.sv
// Port-level checks for the easing curve evaluator, bound to the top level.
// Depends on ece_pkg and easing_curve_evaluator.
module ece_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ece_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [ece_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ece_pkg::M_TDATA_W-1:0]   m_tdata
);

    // reset empties the output register
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result still valid after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no back-pressure while the consumer takes every result
    a_no_stall: assert property (@(posedge aclk) m_tready |-> s_tready)
        else $error("input stalled although output is ready");

    // linear request in range comes back unchanged while the output stays ready
    a_linear_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tready && (s_tuser == ece_pkg::FUNC_LINEAR) &&
        (s_tdata[ece_pkg::PROG_W-1:ece_pkg::FRAC_BITS] == '0)
        ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid && (m_tdata[ece_pkg::EASED_W-1:0] ==
            ece_pkg::EASED_W'($past(s_tdata[ece_pkg::FRAC_BITS-1:0], 5))))
        else $error("linear result wrong or late");

endmodule

bind easing_curve_evaluator ece_checker u_ece_checker (.*);
